// ===== rtl/rfzp_pkg.sv =====
// rfzp_pkg: shared types and constants of the zero-padded row FIR filter
// no dependencies; imported by every module of the block
`default_nettype none

package rfzp_pkg;

  localparam int unsigned MaxTaps      = 15;
  localparam int unsigned TapW         = 4;
  localparam int unsigned HalfW        = 3;
  localparam int unsigned PosW         = 13;
  localparam int unsigned SampleW      = 16;
  localparam int unsigned CoefW        = 16;
  localparam int unsigned CoefFracBits = 14;
  localparam int unsigned ProdW        = SampleW + CoefW;
  localparam int unsigned GrpSize      = 4;
  localparam int unsigned NumGrps      = 4;
  localparam int unsigned GrpW         = ProdW + 2;
  localparam int unsigned SumW         = GrpW + 1;
  localparam int unsigned CoefsPerReg  = 4;
  localparam int unsigned NumCoefRegs  = 4;
  localparam int unsigned CfgIdxW      = 3;
  localparam int unsigned CfgDataW     = 64;

  localparam logic [PosW-1:0] PosCap  = PosW'(4095);
  localparam logic [TapW-1:0] TapsRst = TapW'(3);

  typedef enum logic [CfgIdxW-1:0] {
    CfgTapCount = 3'd0,
    CfgCoef0    = 3'd1,
    CfgCoef1    = 3'd2,
    CfgCoef2    = 3'd3,
    CfgCoef3    = 3'd4
  } cfg_idx_e;

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic signed [CoefW-1:0]   coef_t;
  typedef logic signed [ProdW-1:0]   prod_t;

  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic                      last_in_row;
  } rfzp_in_t;

  typedef struct packed {
    logic signed [SampleW-1:0] filtered;
    logic                      row_end;
  } rfzp_out_t;

  typedef struct packed {
    logic valid;
    logic row_end;
  } stage_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/rfzp_cell.sv =====
// rfzp_cell: one window cell, holds a sample, passes it on and forms its tap product
// depends on rfzp_pkg
`default_nettype none

module rfzp_cell
  import rfzp_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    shift_en_i,
  input  wire logic    pipe_en_i,
  input  wire logic    zero_i,
  input  wire sample_t sample_i,
  input  wire coef_t   coef_i,
  output sample_t      sample_o,
  output prod_t        prod_o
);

  sample_t sample_q, sample_d;
  prod_t   prod_q, prod_d;

  assign sample_d = zero_i ? '0 : sample_i;
  assign prod_d   = sample_q * coef_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_q <= '0;
    end else if (shift_en_i) begin
      sample_q <= sample_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en_i) begin
      prod_q <= prod_d;
    end
  end

  assign sample_o = sample_q;
  assign prod_o   = prod_q;

endmodule

`default_nettype wire

// ===== rtl/rfzp_sum.sv =====
// rfzp_sum: registered adder tree over the cell products, rounding, saturation, output register
// depends on rfzp_pkg
`default_nettype none

module rfzp_sum
  import rfzp_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       pipe_en_i,
  input  wire stage_ctl_t ctl_i,
  input  wire prod_t      prod_i [MaxTaps],
  output logic            out_valid_o,
  output rfzp_out_t       out_req_o
);

  localparam int unsigned ShrW = SumW - CoefFracBits;
  localparam logic signed [SumW-1:0] RoundBias = SumW'(2 ** (CoefFracBits - 1));
  localparam logic signed [ShrW-1:0] SatMax    = ShrW'((2 ** (SampleW - 1)) - 1);
  localparam logic signed [ShrW-1:0] SatMin    = -ShrW'(2 ** (SampleW - 1));

  logic signed [GrpW-1:0] grp_q [NumGrps];
  logic signed [GrpW-1:0] grp_d [NumGrps];
  logic signed [SumW-1:0] sum_q, sum_d;
  logic signed [SumW-1:0] rnd;
  logic signed [ShrW-1:0] shr;
  sample_t                filt_d;
  stage_ctl_t             ctl2_q, ctl3_q, ctl4_q;
  sample_t                filt_q;

  always_comb begin
    for (int g = 0; g < NumGrps; g++) begin
      grp_d[g] = '0;
      for (int i = 0; i < GrpSize; i++) begin
        if (g * GrpSize + i < MaxTaps) begin
          grp_d[g] = grp_d[g] + GrpW'(prod_i[g * GrpSize + i]);
        end
      end
    end
  end

  always_comb begin
    sum_d = '0;
    for (int g = 0; g < NumGrps; g++) begin
      sum_d = sum_d + SumW'(grp_q[g]);
    end
  end

  assign rnd = sum_q + RoundBias;
  assign shr = rnd[SumW-1:CoefFracBits];

  always_comb begin
    if (shr > SatMax) begin
      filt_d = SatMax[SampleW-1:0];
    end else if (shr < SatMin) begin
      filt_d = SatMin[SampleW-1:0];
    end else begin
      filt_d = shr[SampleW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en_i) begin
      grp_q  <= grp_d;
      sum_q  <= sum_d;
      filt_q <= filt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl2_q <= '0;
      ctl3_q <= '0;
      ctl4_q <= '0;
    end else if (pipe_en_i) begin
      ctl2_q <= ctl_i;
      ctl3_q <= ctl2_q;
      ctl4_q <= ctl3_q;
    end
  end

  assign out_valid_o        = ctl4_q.valid;
  assign out_req_o.filtered = filt_q;
  assign out_req_o.row_end  = ctl4_q.row_end;

endmodule

`default_nettype wire

// ===== rtl/row_fir_zero_padded.sv =====
// row_fir_zero_padded: same-length 1-D FIR over image rows with zero padding
// depends on rfzp_pkg, rfzp_cell, rfzp_sum
//
// Samples enter on the in_* channel, one request per sample, last_in_row set
// on the row's final sample. Results leave on the out_* channel, one per
// sample of the row, row_end set on the row's final result. Coefficients and
// the tap count are written through cfg_we_i / cfg_idx_i / cfg_wdata_i while
// the block is idle.
// Throughput: one sample per cycle while the receiver does not stall. The last
// sample of a row starts a flush of tap_count/2 zero slots through the window
// cells, during which in_stall_o is high.
// A result leaves once the sample (or zero slot) that completes its window has
// passed the cell product stage, two adder tree stages and the rounding/saturation
// output register.
// When the receiver stalls, the whole pipeline holds and in_stall_o goes high
// once the output register is full.
// Reset clears the window, the row position, the pipeline valid flags, sets tap_count
// to 3 and all coefficients to zero.
`default_nettype none

module row_fir_zero_padded
  import rfzp_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire rfzp_in_t            in_req_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output rfzp_out_t                out_req_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i
);

  logic [TapW-1:0]        tap_count_q;
  coef_t                  coef_q [MaxTaps];
  logic                   tap_we;
  logic [NumCoefRegs-1:0] coef_we;

  logic [HalfW-1:0] half;
  logic [TapW-1:0]  span;
  logic [HalfW-1:0] flush_q, flush_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic             clear_q, clear_d;
  logic             adv, zero_slot, slot, slot_last, emit;
  stage_ctl_t       ctl0_q, ctl1_q;
  sample_t          slot_sample;
  sample_t          cell_sample [MaxTaps];
  prod_t            cell_prod [MaxTaps];
  coef_t            cell_coef [MaxTaps];

  // configuration decode
  always_comb begin
    tap_we  = 1'b0;
    coef_we = '0;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgTapCount: tap_we = 1'b1;
        CfgCoef0:    coef_we[0] = 1'b1;
        CfgCoef1:    coef_we[1] = 1'b1;
        CfgCoef2:    coef_we[2] = 1'b1;
        CfgCoef3:    coef_we[3] = 1'b1;
        default: begin
          tap_we  = 1'b0;
          coef_we = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_count_q <= TapsRst;
    end else if (tap_we) begin
      tap_count_q <= cfg_wdata_i[TapW-1:0];
    end
  end

  for (genvar t = 0; t < MaxTaps; t++) begin : g_coef
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        coef_q[t] <= '0;
      end else if (coef_we[t / CoefsPerReg]) begin
        coef_q[t] <= cfg_wdata_i[(t % CoefsPerReg) * CoefW +: CoefW];
      end
    end
  end

  // slot control: real samples, then zero slots flushing the row end
  assign half        = tap_count_q[TapW-1:1];
  assign span        = {half, 1'b0};
  assign adv         = !out_valid_o || !out_stall_i;
  assign zero_slot   = flush_q != '0;
  assign slot        = adv && (zero_slot || in_valid_i);
  assign in_stall_o  = zero_slot || !adv;
  assign slot_last   = zero_slot ? (flush_q == HalfW'(1))
                                 : (in_req_i.last_in_row && (half == '0));
  assign emit        = pos_q >= PosW'(half);
  assign slot_sample = zero_slot ? '0 : in_req_i.sample;

  always_comb begin
    flush_d = flush_q;
    pos_d   = pos_q;
    clear_d = clear_q;
    if (slot) begin
      flush_d = zero_slot ? flush_q - HalfW'(1)
                          : (in_req_i.last_in_row ? half : '0);
      if (slot_last) begin
        pos_d = '0;
      end else if (pos_q != PosCap) begin
        pos_d = pos_q + PosW'(1);
      end
      clear_d = slot_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flush_q <= '0;
      pos_q   <= '0;
      clear_q <= 1'b0;
      ctl0_q  <= '0;
      ctl1_q  <= '0;
    end else begin
      flush_q <= flush_d;
      pos_q   <= pos_d;
      clear_q <= clear_d;
      if (adv) begin
        ctl0_q.valid   <= slot && emit;
        ctl0_q.row_end <= slot_last;
        ctl1_q         <= ctl0_q;
      end
    end
  end

  // chain of window cells
  for (genvar d = 0; d < MaxTaps; d++) begin : g_cell
    localparam logic [TapW-1:0] D = TapW'(d);
    logic [TapW-1:0] tap_idx;

    assign tap_idx      = span - D;
    assign cell_coef[d] = ((span >= D) && (tap_idx < tap_count_q)) ? coef_q[tap_idx] : '0;

    if (d == 0) begin : g_head
      rfzp_cell u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .shift_en_i (slot),
        .pipe_en_i  (adv),
        .zero_i     (1'b0),
        .sample_i   (slot_sample),
        .coef_i     (cell_coef[d]),
        .sample_o   (cell_sample[d]),
        .prod_o     (cell_prod[d])
      );
    end else begin : g_body
      rfzp_cell u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .shift_en_i (slot),
        .pipe_en_i  (adv),
        .zero_i     (clear_q),
        .sample_i   (cell_sample[d-1]),
        .coef_i     (cell_coef[d]),
        .sample_o   (cell_sample[d]),
        .prod_o     (cell_prod[d])
      );
    end
  end

  rfzp_sum u_sum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pipe_en_i   (adv),
    .ctl_i       (ctl1_q),
    .prod_i      (cell_prod),
    .out_valid_o (out_valid_o),
    .out_req_o   (out_req_o)
  );

endmodule

`default_nettype wire
